// ===== rtl/points_to_set_update_macros.svh =====
// ----------------------------------------------------------------------------
// points_to_set_update_macros.svh
// assertion shorthands shared by the points-to engine
// ----------------------------------------------------------------------------
`ifndef POINTS_TO_SET_UPDATE_MACROS_SVH
`define POINTS_TO_SET_UPDATE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PTSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptsu_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsu_pkg
// constraint kinds, control word layout and microprogram of the points-to
// constraint engine
// ----------------------------------------------------------------------------
package ptsu_pkg;

    // field widths of the word ports
    localparam int FUNC_W = 3;
    localparam int NODE_W = 6;
    localparam int ROW_W  = 64;

    // constraint kinds
    localparam logic [FUNC_W-1:0] FN_ADDR       = 3'd0;
    localparam logic [FUNC_W-1:0] FN_COPY       = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOAD       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_STORE_ADDR = 3'd3;
    localparam logic [FUNC_W-1:0] FN_STORE_COPY = 3'd4;
    localparam logic [FUNC_W-1:0] FN_STORE_LOAD = 3'd5;

    // row read source
    typedef enum logic [1:0] {RD_NONE, RD_L, RD_R, RD_IDX} rd_sel_t;
    // where the read row is latched
    typedef enum logic [1:0] {LAT_NONE, LAT_LROW, LAT_RROW, LAT_OUT} lat_t;
    // update of the add set
    typedef enum logic [1:0] {ADD_HOLD, ADD_ONEHOT, ADD_RROW, ADD_ACC} add_op_t;
    // row write
    typedef enum logic [1:0] {WR_NONE, WR_L, WR_IDX} wr_op_t;
    // which set a scan walks
    typedef enum logic {SCAN_R, SCAN_L} scan_t;
    // sequencing
    typedef enum logic [2:0] {
        J_NEXT, J_WAIT_IN, J_FUNC, J_LOOP, J_KIND, J_ALWAYS, J_EMIT
    } jmp_t;

    typedef logic [3:0] pc_t;

    // step addresses
    localparam pc_t P_IDLE   = 4'd0;
    localparam pc_t P_RDL    = 4'd1;
    localparam pc_t P_RDR    = 4'd2;
    localparam pc_t P_DISP   = 4'd3;
    localparam pc_t P_ADDR   = 4'd4;
    localparam pc_t P_COPY   = 4'd5;
    localparam pc_t P_LOAD   = 4'd6;
    localparam pc_t P_LDRN   = 4'd7;
    localparam pc_t P_BRANCH = 4'd8;
    localparam pc_t P_WRL    = 4'd9;
    localparam pc_t P_STORE  = 4'd10;
    localparam pc_t P_STDRN  = 4'd11;
    localparam pc_t P_OUT    = 4'd12;
    localparam pc_t P_EMIT   = 4'd13;

    typedef struct packed {
        rd_sel_t rd;
        lat_t    lat;
        add_op_t add;
        wr_op_t  wr;
        scan_t   scan;
        jmp_t    jmp;
        pc_t     target;
    } cw_t;

    // microprogram rom
    function automatic cw_t ucode(pc_t pc);
        cw_t w;
        w = '{rd: RD_NONE, lat: LAT_NONE, add: ADD_HOLD, wr: WR_NONE,
              scan: SCAN_R, jmp: J_WAIT_IN, target: P_IDLE};
        case (pc)
            P_IDLE: begin
                w.jmp = J_WAIT_IN;
            end
            P_RDL: begin
                w.rd  = RD_L;
                w.jmp = J_NEXT;
            end
            P_RDR: begin
                w.rd  = RD_R;
                w.lat = LAT_LROW;
                w.jmp = J_NEXT;
            end
            P_DISP: begin
                w.lat = LAT_RROW;
                w.jmp = J_FUNC;
            end
            P_ADDR: begin
                w.add    = ADD_ONEHOT;
                w.jmp    = J_ALWAYS;
                w.target = P_BRANCH;
            end
            P_COPY: begin
                w.add    = ADD_RROW;
                w.jmp    = J_ALWAYS;
                w.target = P_BRANCH;
            end
            P_LOAD: begin
                w.rd   = RD_IDX;
                w.add  = ADD_ACC;
                w.scan = SCAN_R;
                w.jmp  = J_LOOP;
            end
            P_LDRN: begin
                w.add = ADD_ACC;
                w.jmp = J_NEXT;
            end
            P_BRANCH: begin
                w.jmp    = J_KIND;
                w.target = P_STORE;
            end
            P_WRL: begin
                w.wr     = WR_L;
                w.jmp    = J_ALWAYS;
                w.target = P_OUT;
            end
            P_STORE: begin
                w.rd   = RD_IDX;
                w.wr   = WR_IDX;
                w.scan = SCAN_L;
                w.jmp  = J_LOOP;
            end
            P_STDRN: begin
                w.wr  = WR_IDX;
                w.jmp = J_NEXT;
            end
            P_OUT: begin
                w.rd  = RD_L;
                w.jmp = J_NEXT;
            end
            P_EMIT: begin
                w.lat    = LAT_OUT;
                w.jmp    = J_EMIT;
                w.target = P_IDLE;
            end
            default: begin
                w.jmp    = J_ALWAYS;
                w.target = P_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ptsu_ram.sv =====
// ----------------------------------------------------------------------------
// ptsu_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ptsu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/points_to_set_update.sv =====
// One word at a time: address-of and copy run no scan; load, store address and store copy
// walk one scan over all rows; store load walks two, the load scan and then the store scan.
// The next word is taken the cycle after the result is registered.
// Scans use the single row read port of the matrix ram and walk one row a cycle.
// Reset clears the per-row valid bits, so every row reads as zero at once; no clearing pass.
// ----------------------------------------------------------------------------
// points_to_set_update
// microcoded andersen constraint engine over a bit matrix of points-to sets
// ----------------------------------------------------------------------------
`include "points_to_set_update_macros.svh"

module points_to_set_update #(
    parameter int NODES = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ptsu_pkg::FUNC_W-1:0] s_func,
    input  logic [ptsu_pkg::NODE_W-1:0] s_lhs_node,
    input  logic [ptsu_pkg::NODE_W-1:0] s_rhs_node,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ptsu_pkg::ROW_W-1:0]  m_lhs_row,
    output logic                        m_changed
);

    localparam int AW = $clog2(NODES);
    localparam logic [AW-1:0] LAST = AW'(NODES - 1);

    // sequencer state
    ptsu_pkg::pc_t pc_reg, pc_next;
    ptsu_pkg::cw_t cw;

    // captured word
    logic [ptsu_pkg::FUNC_W-1:0] func_reg;
    logic [ptsu_pkg::NODE_W-1:0] lhs_reg, rhs_reg;
    logic                        lok_reg, ok_reg;

    // datapath
    logic [NODES-1:0] lrow_reg, lrow_next;
    logic [NODES-1:0] rrow_reg, rrow_next;
    logic [NODES-1:0] add_reg, add_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    widx_reg, widx_next;
    logic             pend_reg, pend_next;
    logic             ch_reg, ch_next;
    logic             rv_reg, rv_next;
    logic [NODES-1:0] valid_reg, valid_next;

    // result word
    logic                       m_valid_reg, m_valid_next;
    logic [ptsu_pkg::ROW_W-1:0] m_lhs_row_reg, m_lhs_row_next;
    logic                       m_changed_reg, m_changed_next;

    // ram port
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [NODES-1:0] ram_wdata, ram_q, rd_row;
    logic [NODES-1:0] merged;
    logic             sel_bit, accept, out_free;

    ptsu_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign cw       = ptsu_pkg::ucode(pc_reg);
    assign s_ready  = (pc_reg == ptsu_pkg::P_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_row   = rv_reg ? ram_q : '0;
    assign sel_bit  = (cw.scan == ptsu_pkg::SCAN_R) ? rrow_reg[idx_reg] : lrow_reg[idx_reg];

    // read address
    always_comb begin
        case (cw.rd)
            ptsu_pkg::RD_L:   ram_raddr = lhs_reg[AW-1:0];
            ptsu_pkg::RD_R:   ram_raddr = rhs_reg[AW-1:0];
            ptsu_pkg::RD_IDX: ram_raddr = idx_reg;
            default:          ram_raddr = '0;
        endcase
        ram_re  = (cw.rd != ptsu_pkg::RD_NONE);
        rv_next = ram_re ? valid_reg[ram_raddr] : rv_reg;
    end

    // row write and change detect
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = widx_reg;
        merged    = rd_row | add_reg;
        ram_wdata = merged;
        ch_next   = ch_reg;
        case (cw.wr)
            ptsu_pkg::WR_L: begin
                ram_we    = 1'b1;
                ram_waddr = lhs_reg[AW-1:0];
                ram_wdata = lrow_reg | add_reg;
                ch_next   = ch_reg || ((lrow_reg | add_reg) != lrow_reg);
            end
            ptsu_pkg::WR_IDX: begin
                ram_we  = pend_reg;
                ch_next = ch_reg || (pend_reg && (merged != rd_row));
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        if (accept) begin
            ch_next = 1'b0;
        end
        valid_next = valid_reg;
        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    // add set, latches and scan counter
    always_comb begin
        lrow_next = (cw.lat == ptsu_pkg::LAT_LROW) ? rd_row : lrow_reg;
        rrow_next = (cw.lat == ptsu_pkg::LAT_RROW) ? rd_row : rrow_reg;
        case (cw.add)
            ptsu_pkg::ADD_ONEHOT: add_next = NODES'(1) << rhs_reg[AW-1:0];
            ptsu_pkg::ADD_RROW:   add_next = rrow_reg;
            ptsu_pkg::ADD_ACC:    add_next = add_reg | (pend_reg ? rd_row : '0);
            default:              add_next = add_reg;
        endcase
        pend_next = (cw.rd == ptsu_pkg::RD_IDX) ? sel_bit : 1'b0;
        widx_next = (cw.rd == ptsu_pkg::RD_IDX) ? idx_reg : widx_reg;
        idx_next  = idx_reg;
        if (cw.jmp == ptsu_pkg::J_LOOP) begin
            idx_next = (idx_reg == LAST) ? '0 : idx_reg + AW'(1);
        end
        if (accept) begin
            add_next = '0;
            idx_next = '0;
        end
    end

    // sequencer and result word
    always_comb begin
        pc_next        = pc_reg + 4'd1;
        m_valid_next   = m_valid_reg && !m_ready;
        m_lhs_row_next = m_lhs_row_reg;
        m_changed_next = m_changed_reg;
        case (cw.jmp)
            ptsu_pkg::J_WAIT_IN: begin
                pc_next = accept ? pc_reg + 4'd1 : pc_reg;
            end
            ptsu_pkg::J_FUNC: begin
                if (!ok_reg) begin
                    pc_next = ptsu_pkg::P_OUT;
                end else if (func_reg == ptsu_pkg::FN_ADDR
                             || func_reg == ptsu_pkg::FN_STORE_ADDR) begin
                    pc_next = ptsu_pkg::P_ADDR;
                end else if (func_reg == ptsu_pkg::FN_COPY
                             || func_reg == ptsu_pkg::FN_STORE_COPY) begin
                    pc_next = ptsu_pkg::P_COPY;
                end else begin
                    pc_next = ptsu_pkg::P_LOAD;
                end
            end
            ptsu_pkg::J_LOOP: begin
                pc_next = (idx_reg == LAST) ? pc_reg + 4'd1 : pc_reg;
            end
            ptsu_pkg::J_KIND: begin
                pc_next = (func_reg >= ptsu_pkg::FN_STORE_ADDR) ? cw.target : pc_reg + 4'd1;
            end
            ptsu_pkg::J_ALWAYS: begin
                pc_next = cw.target;
            end
            ptsu_pkg::J_EMIT: begin
                pc_next = pc_reg;
                if (out_free) begin
                    pc_next        = cw.target;
                    m_valid_next   = 1'b1;
                    m_lhs_row_next = lok_reg ? ptsu_pkg::ROW_W'(rd_row) : '0;
                    m_changed_next = ch_reg;
                end
            end
            default: begin
                pc_next = pc_reg + 4'd1;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= ptsu_pkg::P_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            pend_reg    <= 1'b0;
            rv_reg      <= 1'b0;
            ch_reg      <= 1'b0;
            idx_reg     <= '0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            valid_reg   <= valid_next;
            pend_reg    <= pend_next;
            rv_reg      <= rv_next;
            ch_reg      <= ch_next;
            idx_reg     <= idx_next;
        end
        if (accept) begin
            func_reg <= s_func;
            lhs_reg  <= s_lhs_node;
            rhs_reg  <= s_rhs_node;
            lok_reg  <= (int'(s_lhs_node) < NODES);
            ok_reg   <= (int'(s_lhs_node) < NODES) && (int'(s_rhs_node) < NODES)
                        && (s_func <= ptsu_pkg::FN_STORE_LOAD);
        end
        lrow_reg      <= lrow_next;
        rrow_reg      <= rrow_next;
        add_reg       <= add_next;
        widx_reg      <= widx_next;
        m_lhs_row_reg <= m_lhs_row_next;
        m_changed_reg <= m_changed_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_lhs_row = m_lhs_row_reg;
    assign m_changed = m_changed_reg;

    // checks
    `PTSU_ASSERT_SAME(a_no_write_idle, pc_reg == ptsu_pkg::P_IDLE, !ram_we,
        "row write while idle")
    `PTSU_ASSERT_SAME(a_store_addr, ram_we && pc_reg != ptsu_pkg::P_WRL,
        ram_waddr == $past(ram_raddr), "store write not to the row just read")
    `PTSU_ASSERT_NEXT(a_loop_wrap,
        (pc_reg == ptsu_pkg::P_LOAD || pc_reg == ptsu_pkg::P_STORE) && idx_reg == LAST,
        idx_reg == '0, "scan counter did not wrap")
    `PTSU_ASSERT_SAME(a_pc_range, 1'b1, pc_reg <= ptsu_pkg::P_EMIT,
        "step counter outside program")

endmodule
